@@ src/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// pfa_pkg
// shared types and constants of the page frame allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int unsigned FRAMES      = 32;
  localparam int unsigned IDX_W       = $clog2(FRAMES);
  localparam int unsigned CNT_W       = $clog2(FRAMES + 1);
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned AMOUNT_W    = 32;
  localparam int unsigned DIR_W       = 10;
  localparam int unsigned FREE_W      = 6;
  localparam int unsigned FRAME_SHIFT = 22;
  localparam int unsigned NEED_W      = AMOUNT_W + 1;

  localparam logic [1:0] OP_CHECK = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  // rounding term for ceil(amount / frame size)
  localparam logic [NEED_W-1:0] FRAME_ROUND = NEED_W'((64'd1 << FRAME_SHIFT) - 64'd1);

  typedef struct packed {
    logic [1:0]          operation;
    logic [AMOUNT_W-1:0] amount;
    logic [ADDR_W-1:0]   virt_addr;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic              dir_write;
    logic [DIR_W-1:0]  dir_index;
    logic [DIR_W-1:0]  frame_number;
    logic              present_flag;
    logic              writable_flag;
    logic              user_flag;
    logic              large_page_flag;
    logic [FREE_W-1:0] free_frames;
  } res_t;

  // bitmap update command
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] idx;
  } bm_cmd_t;

endpackage

@@ src/page_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// page_frame_allocator
// first fit 4 MiB frame allocator with used bitmap and owner address ram
// ----------------------------------------------------------------------------
// latency: check, unknown op and allocate on a full pool give the result in
//   the cycle after the accepting edge; allocate scans up to the lowest free index,
//   free scans up to the matching index, comparing each owner after its ram read
// throughput: one item at a time, one scan step per cycle; next beat taken while a result shows
// reset: frame 0 used, free count FRAMES - 1; owner ram is not cleared
// the receiver cannot stall: each result is on res_o for one cycle with done_o
module page_frame_allocator (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  pfa_pkg::req_t   req_i,
  output logic            done_o,
  output pfa_pkg::res_t   res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_FREE
  } state_e;

  state_e                          state_q, state_d;
  logic [pfa_pkg::CNT_W-1:0]       scan_q, scan_d;       // next frame to visit
  logic [pfa_pkg::IDX_W-1:0]       cmp_idx_q, cmp_idx_d; // frame whose owner is in rdata
  logic                            cmp_vld_q, cmp_vld_d;
  logic [pfa_pkg::ADDR_W-1:0]      vaddr_q, vaddr_d;
  logic                            done_q, done_d;
  pfa_pkg::res_t                   res_q, res_d;

  pfa_pkg::bm_cmd_t                bm_cmd;
  logic [pfa_pkg::IDX_W-1:0]       bm_rd_idx;
  logic                            bm_used;
  logic [pfa_pkg::CNT_W-1:0]       free_cnt;

  logic                            ram_we;
  logic                            ram_re;
  logic [pfa_pkg::IDX_W-1:0]       ram_raddr;
  logic [pfa_pkg::ADDR_W-1:0]      ram_rdata;

  logic [pfa_pkg::NEED_W-1:0]      needed;
  logic                            accept;
  logic                            owner_hit;

  pfa_bitmap u_bitmap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (bm_cmd),
    .rd_idx_i (bm_rd_idx),
    .used_o   (bm_used),
    .count_o  (free_cnt)
  );

  // owner address per frame; written on allocate, read during the free scan
  pfa_ram #(
    .DEPTH (pfa_pkg::FRAMES),
    .WIDTH (pfa_pkg::ADDR_W)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (scan_q[pfa_pkg::IDX_W-1:0]),
    .wdata_i (vaddr_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // frames needed by a check, 33 bits so the rounding cannot wrap
  assign needed = (pfa_pkg::NEED_W'(req_i.amount) + pfa_pkg::FRAME_ROUND) >> pfa_pkg::FRAME_SHIFT;

  // the allocate scan looks at the bitmap directly, the free scan in the cycle
  // after the ram read
  assign bm_rd_idx = (state_q == ST_ALLOC) ? scan_q[pfa_pkg::IDX_W-1:0] : cmp_idx_q;
  assign owner_hit = cmp_vld_q && bm_used && (ram_rdata == vaddr_q);
  assign ram_raddr = scan_q[pfa_pkg::IDX_W-1:0];

  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = cmp_vld_q;
    vaddr_d   = vaddr_q;
    done_d    = 1'b0;
    res_d     = '0;
    res_d.free_frames = pfa_pkg::FREE_W'(free_cnt);
    bm_cmd    = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          vaddr_d   = req_i.virt_addr;
          scan_d    = '0;
          cmp_vld_d = 1'b0;
          case (req_i.operation)
            pfa_pkg::OP_CHECK: begin
              done_d   = 1'b1;
              res_d.ok = (pfa_pkg::NEED_W'(free_cnt) >= needed);
            end
            pfa_pkg::OP_ALLOC: begin
              if (free_cnt == '0) begin
                done_d = 1'b1;   // full pool
              end else begin
                state_d = ST_ALLOC;
              end
            end
            pfa_pkg::OP_FREE: begin
              state_d = ST_FREE;
            end
            default: begin
              done_d = 1'b1;     // unknown op: plain failure
            end
          endcase
        end
      end

      ST_ALLOC: begin
        if (!bm_used) begin
          // lowest free frame found
          ram_we     = 1'b1;
          bm_cmd.set = 1'b1;
          bm_cmd.idx = scan_q[pfa_pkg::IDX_W-1:0];
          done_d     = 1'b1;
          state_d    = ST_IDLE;
          res_d.ok              = 1'b1;
          res_d.dir_write       = 1'b1;
          res_d.dir_index       = vaddr_q[pfa_pkg::ADDR_W-1 -: pfa_pkg::DIR_W];
          res_d.frame_number    = pfa_pkg::DIR_W'(scan_q[pfa_pkg::IDX_W-1:0]);
          res_d.present_flag    = 1'b1;
          res_d.writable_flag   = 1'b1;
          res_d.user_flag       = 1'b1;
          res_d.large_page_flag = 1'b1;
          res_d.free_frames     = pfa_pkg::FREE_W'(free_cnt - pfa_pkg::CNT_W'(1));
        end else if (scan_q == pfa_pkg::CNT_W'(pfa_pkg::FRAMES - 1)) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          scan_d = scan_q + pfa_pkg::CNT_W'(1);
        end
      end

      ST_FREE: begin
        if (owner_hit) begin
          bm_cmd.clr = 1'b1;
          bm_cmd.idx = cmp_idx_q;
          done_d     = 1'b1;
          state_d    = ST_IDLE;
          res_d.ok           = 1'b1;
          res_d.dir_write    = 1'b1;
          res_d.dir_index    = vaddr_q[pfa_pkg::ADDR_W-1 -: pfa_pkg::DIR_W];
          res_d.frame_number = pfa_pkg::DIR_W'(cmp_idx_q);
          res_d.free_frames  = pfa_pkg::FREE_W'(free_cnt + pfa_pkg::CNT_W'(1));
        end else if (scan_q == pfa_pkg::CNT_W'(pfa_pkg::FRAMES)) begin
          // last owner compared, no match
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          cmp_idx_d = scan_q[pfa_pkg::IDX_W-1:0];
          cmp_vld_d = 1'b1;
          scan_d    = scan_q + pfa_pkg::CNT_W'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      scan_q    <= '0;
      cmp_idx_q <= '0;
      cmp_vld_q <= 1'b0;
      vaddr_q   <= '0;
      done_q    <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      scan_q    <= scan_d;
      cmp_idx_q <= cmp_idx_d;
      cmp_vld_q <= cmp_vld_d;
      vaddr_q   <= vaddr_d;
      done_q    <= done_d;
      res_q     <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_write_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.dir_write) |-> res_q.ok)
    else $error("directory write on a failed beat");

  a_write_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.dir_write) |-> (state_q == ST_IDLE) && $past(state_q != ST_IDLE))
    else $error("write result without a finished scan");

  a_no_done_midscan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !done_q)
    else $error("result issued while scan continues");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt <= pfa_pkg::CNT_W'(pfa_pkg::FRAMES - 1))
    else $error("free count above pool size");

endmodule

@@ src/pfa_ram.sv @@
// ----------------------------------------------------------------------------
// pfa_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/pfa_bitmap.sv @@
// ----------------------------------------------------------------------------
// pfa_bitmap
// used bit per frame and free frame count
// ----------------------------------------------------------------------------
module pfa_bitmap (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pfa_pkg::bm_cmd_t          cmd_i,
  input  logic [pfa_pkg::IDX_W-1:0] rd_idx_i,
  output logic                      used_o,
  output logic [pfa_pkg::CNT_W-1:0] count_o
);

  logic [pfa_pkg::FRAMES-1:0] used_q, used_d;
  logic [pfa_pkg::CNT_W-1:0]  count_q, count_d;

  always_comb begin
    used_d  = used_q;
    count_d = count_q;
    if (cmd_i.set) begin
      used_d[cmd_i.idx] = 1'b1;
      count_d           = count_q - pfa_pkg::CNT_W'(1);
    end else if (cmd_i.clr) begin
      used_d[cmd_i.idx] = 1'b0;
      count_d           = count_q + pfa_pkg::CNT_W'(1);
    end
  end

  // frame 0 is reserved from reset on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= pfa_pkg::FRAMES'(1);
      count_q <= pfa_pkg::CNT_W'(pfa_pkg::FRAMES - 1);
    end else begin
      used_q  <= used_d;
      count_q <= count_d;
    end
  end

  assign used_o  = used_q[rd_idx_i];
  assign count_o = count_q;

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(~used_q) == int'(count_q))
    else $error("free count out of step with bitmap");

  a_frame0_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q[0])
    else $error("reserved frame released");

endmodule
